### rtl/pstt_pkg.sv
// shared constants, codes and controller/datapath interface types for the stats table
package pstt_pkg;

  // number of table slots, the last one is the shared overflow bucket
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

  localparam int ADDR_W = 7;
  localparam int STAT_W = 16;
  localparam int CNT_W = 32;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_query;
    logic out_blocked;
  } dp_status_t;

endpackage

### rtl/pstt_ctrl.sv
// controller state machine: accept, scan, execute
module pstt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pstt_pkg::dp_status_t sts,
  output pstt_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a query waits while the previous result is still unclaimed
        if (!(sts.is_query && sts.out_blocked)) begin
          cmd.exec = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/pstt_datapath.sv
// datapath: request latch, slot table, scan index and result register
module pstt_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pstt_pkg::ctrl_cmd_t                cmd,
  output pstt_pkg::dp_status_t               sts,
  input  logic [1:0]                         in_operation,
  input  logic [pstt_pkg::ADDR_W-1:0]        in_device_address,
  input  logic signed [pstt_pkg::STAT_W-1:0] in_status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [pstt_pkg::CNT_W-1:0]         out_txn_total,
  output logic [pstt_pkg::CNT_W-1:0]         out_err_total,
  output logic signed [pstt_pkg::STAT_W-1:0] out_last_error
);

  localparam int N = pstt_pkg::TABLE_ENTRIES;
  localparam int IW = pstt_pkg::IDX_W;

  // request latch
  logic [1:0]                  op_r;
  logic [pstt_pkg::ADDR_W-1:0] addr_r;
  logic [pstt_pkg::STAT_W-1:0] status_r;

  // table, contents undefined until a slot is claimed
  logic [pstt_pkg::ADDR_W-1:0] key_r [N];
  logic [pstt_pkg::CNT_W-1:0]  txns_r [N];
  logic [pstt_pkg::CNT_W-1:0]  errs_r [N];
  logic [pstt_pkg::STAT_W-1:0] last_r [N];

  logic [IW-1:0] used_r;
  logic          ovf_r;

  // scan
  logic [IW-1:0] idx_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;

  logic out_valid_r;
  logic out_found_r;
  logic [pstt_pkg::CNT_W-1:0]  out_txn_r;
  logic [pstt_pkg::CNT_W-1:0]  out_err_r;
  logic [pstt_pkg::STAT_W-1:0] out_last_r;

  logic          in_range;
  logic          match;
  logic          full;
  logic          fresh;
  logic [IW-1:0] slot;
  logic [pstt_pkg::CNT_W-1:0] txn_base;
  logic [pstt_pkg::CNT_W-1:0] err_base;
  logic          is_err;

  assign in_range = idx_r < used_r;
  assign match = in_range && (key_r[idx_r] == addr_r);
  assign full = (used_r == pstt_pkg::LAST_SLOT);

  always_comb begin
    if (hit_r) begin
      slot = hit_idx_r;
      fresh = 1'b0;
    end else if (!full) begin
      slot = used_r;
      fresh = 1'b1;
    end else begin
      slot = pstt_pkg::LAST_SLOT;
      fresh = !ovf_r;
    end
  end

  assign txn_base = fresh ? '0 : txns_r[slot];
  assign err_base = fresh ? '0 : errs_r[slot];
  assign is_err = (status_r != '0);

  assign sts.scan_done = !in_range || match;
  assign sts.is_query = (op_r == pstt_pkg::OP_QUERY);
  assign sts.out_blocked = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      addr_r <= in_device_address;
      status_r <= in_status;
      idx_r <= '0;
    end else if (cmd.scan_step && in_range && !match) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.scan_step && match) begin
      hit_idx_r <= idx_r;
    end
    if (cmd.exec && op_r == pstt_pkg::OP_RECORD) begin
      if (fresh) begin
        key_r[slot] <= addr_r;
      end
      txns_r[slot] <= txn_base + 1'b1;
      errs_r[slot] <= is_err ? err_base + 1'b1 : err_base;
      if (is_err) begin
        last_r[slot] <= status_r;
      end else if (fresh) begin
        last_r[slot] <= '0;
      end
    end
    if (cmd.exec && op_r == pstt_pkg::OP_QUERY) begin
      out_found_r <= hit_r;
      out_txn_r <= hit_r ? txns_r[hit_idx_r] : '0;
      out_err_r <= hit_r ? errs_r[hit_idx_r] : '0;
      out_last_r <= hit_r ? last_r[hit_idx_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r <= 1'b0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmd.scan_step && match) begin
        hit_r <= 1'b1;
      end
      if (cmd.exec && op_r == pstt_pkg::OP_RECORD && !hit_r) begin
        if (!full) begin
          used_r <= used_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.exec && op_r == pstt_pkg::OP_CLEAR) begin
        used_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.exec && op_r == pstt_pkg::OP_QUERY) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_txn_total = out_txn_r;
  assign out_err_total = out_err_r;
  assign out_last_error = out_last_r;

endmodule

### rtl/per_address_txn_stats_table.sv
// top level of the per-address bus transaction statistics table
// A request is taken when in_valid and in_ready are both high; in_ready is high only while the
// controller is idle, so one request is in work at a time. Each request passes an accept state,
// then a serial scan of the slots in use (one slot compare per cycle), then an execute state.
// The scan over the key registers sets how long a request takes. A query answer sits in an
// output register
// until out_ready takes it, and the block keeps accepting requests meanwhile; a second query
// waits in its execute state only while the earlier answer is still unclaimed. Records and
// clears give no answer; operation code 3 is accepted and ignored. After reset the table is
// empty and needs no clearing pass.
module per_address_txn_stats_table (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [pstt_pkg::ADDR_W-1:0]        in_device_address,
  input  logic signed [pstt_pkg::STAT_W-1:0] in_status,
  // query answer channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [pstt_pkg::CNT_W-1:0]         out_txn_total,
  output logic [pstt_pkg::CNT_W-1:0]         out_err_total,
  output logic signed [pstt_pkg::STAT_W-1:0] out_last_error
);

  // commands down to the datapath, status back up
  pstt_pkg::ctrl_cmd_t  cmd;
  pstt_pkg::dp_status_t sts;

  // sequencing: idle, slot scan, execute
  pstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, counters and answer register
  pstt_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_device_address (in_device_address),
    .in_status         (in_status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_txn_total     (out_txn_total),
    .out_err_total     (out_err_total),
    .out_last_error    (out_last_error)
  );

endmodule
